/* rtl/tkpe_pkg.sv */
package tkpe_pkg;

	// depth of each key's shift history
	localparam int unsigned HISTORY_BITS = 8;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned THR_W   = 16;
	localparam int unsigned SAMP_W  = 4;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned EVT_W   = 3;

	typedef logic [HISTORY_BITS-1:0] history_t;
	typedef logic [TIME_W-1:0]       ms_t;
	typedef logic [THR_W-1:0]        thr_t;

	typedef enum logic [EVT_W-1:0] {
		EVT_NULL       = 3'd0,
		EVT_K1_QUICK   = 3'd1,
		EVT_K1_SHORT   = 3'd2,
		EVT_K2_SHORT   = 3'd3,
		EVT_BOTH_LONG  = 3'd4,
		EVT_BOTH_VLONG = 3'd5,
		EVT_BOTH_REL   = 3'd6
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEB_EN     = 3'd0,
		REG_DEB_SAMP   = 3'd1,
		REG_MIN_PRESS  = 3'd2,
		REG_MED_PRESS  = 3'd3,
		REG_MAX_SHORT  = 3'd4,
		REG_BOTH_LONG  = 3'd5,
		REG_BOTH_VLONG = 3'd6
	} cfg_idx_t;

	localparam logic [SAMP_W-1:0] DEB_SAMP_RST   = 4'd4;
	localparam thr_t              MIN_PRESS_RST  = 16'd50;
	localparam thr_t              MED_PRESS_RST  = 16'd800;
	localparam thr_t              MAX_SHORT_RST  = 16'd3000;
	localparam thr_t              BOTH_LONG_RST  = 16'd1500;
	localparam thr_t              BOTH_VLONG_RST = 16'd5000;

	// low-bit mask of the newest samples; count clamps to 1..HISTORY_BITS
	function automatic history_t sample_mask(logic [SAMP_W-1:0] samples);
		history_t    m;
		int unsigned n;
		n = int'(samples);
		if (n < 1) n = 1;
		if (n > HISTORY_BITS) n = HISTORY_BITS;
		for (int unsigned i = 0; i < HISTORY_BITS; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

endpackage

/* rtl/tkpe_if.sv */
interface tkpe_poll_if;
	logic                          valid;
	logic                          ready;
	logic                          key_one_raw;
	logic                          key_two_raw;
	logic [tkpe_pkg::TIME_W-1:0]   now_ms;
	logic                          late_release_allowed;
	logic                          display_dimmed;

	modport source (output valid, key_one_raw, key_two_raw, now_ms,
		late_release_allowed, display_dimmed, input ready);
	modport sink (input valid, key_one_raw, key_two_raw, now_ms,
		late_release_allowed, display_dimmed, output ready);
endinterface

interface tkpe_event_if;
	logic                          valid;
	logic                          ready;
	logic [tkpe_pkg::EVT_W-1:0]    event_code;
	logic                          activity;
	logic                          wake_only;
	logic                          keys_idle;

	modport source (output valid, event_code, activity, wake_only, keys_idle,
		input ready);
	modport sink (input valid, event_code, activity, wake_only, keys_idle,
		output ready);
endinterface

/* rtl/tkpe_debounce.sv */
module tkpe_debounce (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 raw,
	input  logic                 enable,
	input  tkpe_pkg::history_t   mask,
	output logic                 level
);
	import tkpe_pkg::*;

	history_t history_q;
	history_t history_nxt;

	// shift every poll, even with debounce off
	assign history_nxt = {history_q[HISTORY_BITS-2:0], raw};
	assign level = enable ? ((history_nxt & mask) == mask) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '1;
		end else if (advance) begin
			history_q <= history_nxt;
		end
	end

endmodule

/* rtl/two_key_press_event_decoder_core.sv */
// Two-key press event decoder.
//
// poll (sink): one request per key poll carrying both raw key levels, the
// free-running millisecond time, the late-release mode flag and the dimmed
// flag. result (source): exactly one result per request with the event code,
// activity, wake_only and keys_idle.
// Configuration: cfg_we/cfg_idx/cfg_wdata write one configuration register per
// edge; write only while no request is in flight.
//
// A request accepted into the input register is decoded in one pass of
// compares and 32-bit time subtractions against the key state and lands
// in the result register once that register has room. Throughput is one
// request per cycle, set by the single decode pass, unless result stalls.
// When result stalls, the result register holds; the input register still
// takes one more request, then poll.ready drops until result drains.
// Reset (arst_n low) clears histories to all pressed, the press tracking flags,
// and loads the register defaults; no clearing pass is needed.
module two_key_press_event_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	tkpe_poll_if.sink                       poll,
	tkpe_event_if.source                    result,
	input  logic                            cfg_we,
	input  logic [tkpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tkpe_pkg::CFG_W-1:0]      cfg_wdata
);
	import tkpe_pkg::*;

	// configuration registers
	logic              deb_en_q;
	logic [SAMP_W-1:0] deb_samp_q;
	thr_t              min_press_q, med_press_q, max_short_q;
	thr_t              both_long_q, both_vlong_q;

	// input stage
	logic valid_s1;
	logic r1_s1, r2_s1, late_s1, dim_s1;
	ms_t  now_s1;

	// key tracking state
	ms_t  t1_q, t2_q, tboth_q;
	logic v1_q, v2_q, prev1_q, prev2_q, both_prev_q;
	logic long_done_q, vlong_done_q, rel_done_q, locked_q, both_open_q;

	// result register
	logic   out_valid_q;
	event_t evt_q;
	logic   act_q, wake_q, idle_q;

	logic     advance;
	logic     b1, b2, both_held;
	history_t mask;

	// next-state values of one decode pass
	ms_t    t1_d, t2_d, tboth_d;
	ms_t    dur1, dur2, dur_both;
	logic   v1_d, v2_d;
	logic   long_done_d, vlong_done_d, rel_done_d, locked_d, both_open_d;
	event_t evt_d, evt_out;
	logic   act_d, wake_d, idle_d;

	// move the staged request into the result register when it has room
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_en_q     <= 1'b1;
			deb_samp_q   <= DEB_SAMP_RST;
			min_press_q  <= MIN_PRESS_RST;
			med_press_q  <= MED_PRESS_RST;
			max_short_q  <= MAX_SHORT_RST;
			both_long_q  <= BOTH_LONG_RST;
			both_vlong_q <= BOTH_VLONG_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				REG_DEB_EN:     deb_en_q     <= cfg_wdata[0];
				REG_DEB_SAMP:   deb_samp_q   <= cfg_wdata[SAMP_W-1:0];
				REG_MIN_PRESS:  min_press_q  <= cfg_wdata[THR_W-1:0];
				REG_MED_PRESS:  med_press_q  <= cfg_wdata[THR_W-1:0];
				REG_MAX_SHORT:  max_short_q  <= cfg_wdata[THR_W-1:0];
				REG_BOTH_LONG:  both_long_q  <= cfg_wdata[THR_W-1:0];
				REG_BOTH_VLONG: both_vlong_q <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			r1_s1   <= poll.key_one_raw;
			r2_s1   <= poll.key_two_raw;
			now_s1  <= poll.now_ms;
			late_s1 <= poll.late_release_allowed;
			dim_s1  <= poll.display_dimmed;
		end
	end

	assign mask = sample_mask(deb_samp_q);

	tkpe_debounce u_deb_one (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.raw     (r1_s1),
		.enable  (deb_en_q),
		.mask    (mask),
		.level   (b1)
	);

	tkpe_debounce u_deb_two (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.raw     (r2_s1),
		.enable  (deb_en_q),
		.mask    (mask),
		.level   (b2)
	);

	assign both_held = b1 && b2;
	assign dur1      = now_s1 - t1_q;
	assign dur2      = now_s1 - t2_q;
	assign dur_both  = now_s1 - tboth_q;

	always_comb begin
		t1_d         = t1_q;
		t2_d         = t2_q;
		tboth_d      = tboth_q;
		v1_d         = v1_q;
		v2_d         = v2_q;
		long_done_d  = long_done_q;
		vlong_done_d = vlong_done_q;
		rel_done_d   = rel_done_q;
		locked_d     = locked_q;
		both_open_d  = both_open_q;
		evt_d        = EVT_NULL;

		// both keys up: unlock singles, arm a new both sequence
		if (!b1 && !b2) begin
			locked_d    = 1'b0;
			both_open_d = 1'b1;
		end

		if (both_held) begin
			// singles are void once both keys are held
			locked_d = 1'b1;
			v1_d     = 1'b0;
			v2_d     = 1'b0;
			if (both_open_d) begin
				both_open_d  = 1'b0;
				tboth_d      = now_s1;
				long_done_d  = 1'b0;
				vlong_done_d = 1'b0;
				rel_done_d   = 1'b0;
			end else begin
				if (dur_both >= ms_t'(both_long_q) && !long_done_q) begin
					long_done_d = 1'b1;
					evt_d       = EVT_BOTH_LONG;
				end
				// very long wins when both thresholds fall in one poll
				if (dur_both >= ms_t'(both_vlong_q) && !vlong_done_q) begin
					vlong_done_d = 1'b1;
					evt_d        = EVT_BOTH_VLONG;
				end
			end
		end else if (both_prev_q) begin
			if (dur_both >= ms_t'(both_long_q) && !vlong_done_q && !long_done_q) begin
				if (late_s1) evt_d = EVT_BOTH_LONG;
			end else if (!b1 && !b2 && long_done_q && !vlong_done_q && !rel_done_q) begin
				rel_done_d = 1'b1;
				evt_d      = EVT_BOTH_REL;
			end
		end else if (!locked_d) begin
			if (prev1_q && !b1) begin
				if (v1_q) begin
					if (dur1 > ms_t'(min_press_q) && dur1 <= ms_t'(med_press_q)) begin
						evt_d = EVT_K1_QUICK;
					end else if (dur1 > ms_t'(med_press_q) &&
						dur1 < ms_t'(max_short_q)) begin
						evt_d = EVT_K1_SHORT;
					end
				end
			end else if (!prev1_q && b1) begin
				t1_d = now_s1;
				v1_d = 1'b1;
			end
			if (prev2_q && !b2) begin
				if (v2_q && dur2 > ms_t'(min_press_q) && dur2 < ms_t'(max_short_q)) begin
					evt_d = EVT_K2_SHORT;
				end
			end else if (!prev2_q && b2) begin
				t2_d = now_s1;
				v2_d = 1'b1;
			end
		end

		// both keys released: drop the both sequence
		if (!b1 && !b2) begin
			both_open_d  = 1'b1;
			long_done_d  = 1'b0;
			vlong_done_d = 1'b0;
			rel_done_d   = 1'b0;
		end

		// swallow the event while dimmed, wake only
		act_d   = (evt_d != EVT_NULL);
		wake_d  = act_d && dim_s1;
		evt_out = wake_d ? EVT_NULL : evt_d;
		idle_d  = !r1_s1 && !r2_s1 && !b1 && !b2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q         <= 1'b0;
			v2_q         <= 1'b0;
			prev1_q      <= 1'b0;
			prev2_q      <= 1'b0;
			both_prev_q  <= 1'b0;
			long_done_q  <= 1'b0;
			vlong_done_q <= 1'b0;
			rel_done_q   <= 1'b0;
			locked_q     <= 1'b0;
			both_open_q  <= 1'b1;
		end else if (advance) begin
			v1_q         <= v1_d;
			v2_q         <= v2_d;
			prev1_q      <= b1;
			prev2_q      <= b2;
			both_prev_q  <= both_held;
			long_done_q  <= long_done_d;
			vlong_done_q <= vlong_done_d;
			rel_done_q   <= rel_done_d;
			locked_q     <= locked_d;
			both_open_q  <= both_open_d;
		end
	end

	// press times are only read behind their valid flags or a running both sequence
	always_ff @(posedge clk) begin
		if (advance) begin
			t1_q    <= t1_d;
			t2_q    <= t2_d;
			tboth_q <= tboth_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			evt_q  <= evt_out;
			act_q  <= act_d;
			wake_q <= wake_d;
			idle_q <= idle_d;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.event_code = evt_q;
	assign result.activity   = act_q;
	assign result.wake_only  = wake_q;
	assign result.keys_idle  = idle_q;

	// a swallowed event still reports activity but carries no code
	a_wake_clears_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wake_q |-> act_q && evt_q == EVT_NULL)
		else $error("wake_only result carries an event code");

	a_code_sets_activity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evt_q != EVT_NULL |-> act_q)
		else $error("event code without activity");

	a_both_held_closed: assert property (@(posedge clk) disable iff (!arst_n)
		both_prev_q |-> !both_open_q)
		else $error("both keys held but sequence still open");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a staged request");

endmodule
